/* rtl/core/rrf_pkg.sv */
// Shared types, latencies and mode codes for the ray reflect/refract/Fresnel unit.
`timescale 1ns / 1ps

package rrf_pkg;

    // Latency of the pipelined square root and divider (one digit per stage)
    localparam int SQRT_LAT = 32;
    localparam int DIV_LAT  = 32;

    // Vector path: 7 front stages, 8 mid stages, 1 pre-divide, 1 final stage
    localparam int VEC_LAT = 17 + 2 * SQRT_LAT + DIV_LAT;
    // Fresnel path: 1 setup stage, divider, 6 back stages
    localparam int SCH_LAT = DIV_LAT + 7;
    // Delay ahead of the Fresnel path so both paths line up
    localparam int SCH_PAD = VEC_LAT - SCH_LAT;

    typedef enum logic [1:0] {
        MODE_REFLECT = 2'd0,
        MODE_REFRACT = 2'd1,
        MODE_SCHLICK = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    // Geometry of one ray query
    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic        [15:0] ratio;
    } ray_t;

    // Result of the vector path
    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic               ray_ok;
    } vec_res_t;

endpackage

/* rtl/core/rrf_sqrt.sv */
// Pipelined integer square root, floor of a 64-bit radicand, two bits per stage.
`timescale 1ns / 1ps

module rrf_sqrt
    import rrf_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] rad,
    output logic [31:0] root
);

    logic [63:0] rad_reg  [SQRT_LAT];
    logic [35:0] rem_reg  [SQRT_LAT];
    logic [31:0] root_reg [SQRT_LAT];
    logic [63:0] rad_next  [SQRT_LAT];
    logic [35:0] rem_next  [SQRT_LAT];
    logic [31:0] root_next [SQRT_LAT];

    // One restoring root digit per stage
    always_comb
    begin
        logic [63:0] src_rad;
        logic [35:0] src_rem;
        logic [31:0] src_root;
        logic [35:0] rem2;
        logic [35:0] trial;
        for (int k = 0; k < SQRT_LAT; k++)
        begin
            if (k == 0)
            begin
                src_rad  = rad;
                src_rem  = '0;
                src_root = '0;
            end
            else
            begin
                src_rad  = rad_reg[k-1];
                src_rem  = rem_reg[k-1];
                src_root = root_reg[k-1];
            end
            rem2  = {src_rem[33:0], src_rad[63:62]};
            trial = {2'b00, src_root, 2'b01};
            if (rem2 >= trial)
            begin
                rem_next[k]  = rem2 - trial;
                root_next[k] = {src_root[30:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = rem2;
                root_next[k] = {src_root[30:0], 1'b0};
            end
            rad_next[k] = {src_rad[61:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQRT_LAT; k++)
            begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root = root_reg[SQRT_LAT-1];

endmodule

/* rtl/core/rrf_div.sv */
// Pipelined unsigned divider, 48-bit numerator by 32-bit divisor, one quotient bit per stage.
`timescale 1ns / 1ps

module rrf_div
    import rrf_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [47:0] num,   // must be below den * 2^32
    input  logic [31:0] den,
    output logic [31:0] quo
);

    logic [31:0] rem_reg [DIV_LAT];
    logic [31:0] low_reg [DIV_LAT];
    logic [31:0] quo_reg [DIV_LAT];
    logic [31:0] den_reg [DIV_LAT];
    logic [31:0] rem_next [DIV_LAT];
    logic [31:0] low_next [DIV_LAT];
    logic [31:0] quo_next [DIV_LAT];
    logic [31:0] den_next [DIV_LAT];

    // Shift in one numerator bit, subtract when it fits
    always_comb
    begin
        logic [31:0] src_rem;
        logic [31:0] src_low;
        logic [31:0] src_quo;
        logic [31:0] src_den;
        logic [32:0] rem2;
        for (int k = 0; k < DIV_LAT; k++)
        begin
            if (k == 0)
            begin
                src_rem = {16'h0000, num[47:32]};
                src_low = num[31:0];
                src_quo = '0;
                src_den = den;
            end
            else
            begin
                src_rem = rem_reg[k-1];
                src_low = low_reg[k-1];
                src_quo = quo_reg[k-1];
                src_den = den_reg[k-1];
            end
            rem2 = {src_rem, src_low[31]};
            if (rem2 >= {1'b0, src_den})
            begin
                rem_next[k] = 32'(rem2 - {1'b0, src_den});
                quo_next[k] = {src_quo[30:0], 1'b1};
            end
            else
            begin
                rem_next[k] = rem2[31:0];
                quo_next[k] = {src_quo[30:0], 1'b0};
            end
            low_next[k] = {src_low[30:0], 1'b0};
            den_next[k] = src_den;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_LAT; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= den_next[k];
            end
        end
    end

    assign quo = quo_reg[DIV_LAT-1];

endmodule

/* rtl/core/rrf_vec.sv */
// Vector path: mirror reflection and Snell refraction with normalization.
`timescale 1ns / 1ps

module rrf_vec
    import rrf_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  logic     refl_in,   // 1 mirror, 0 refract
    input  ray_t     ray,
    output vec_res_t res
);

    typedef struct packed {
        logic [2:0][15:0] ro;     // mirrored vector
        logic             refl;
        logic             dpos;   // discriminant strictly positive
    } tail_t;

    typedef struct packed {
        logic [2:0][60:0] e;
        logic [2:0][15:0] n;
        tail_t            tl;
    } mid_t;

    typedef struct packed {
        logic [2:0][31:0] rn;
        tail_t            tl;
        logic             mz;
    } back_t;

    typedef struct packed {
        logic [2:0]       neg;
        tail_t            tl;
        logic             zero;
    } fin_t;

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767)
            return 16'sh7fff;
        else if (v < -64'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    logic signed [15:0] d0 [3];
    logic signed [15:0] n0 [3];

    always_comb
    begin
        d0[0] = ray.dir_x;
        d0[1] = ray.dir_y;
        d0[2] = ray.dir_z;
        n0[0] = ray.norm_x;
        n0[1] = ray.norm_y;
        n0[2] = ray.norm_z;
    end

    // Stage 1 to 7: dot product, mirror, discriminant
    logic signed [31:0] p1_reg [3];
    logic signed [15:0] d1_reg [3], n1_reg [3];
    logic        [15:0] eta1_reg;
    logic               refl1_reg;

    logic signed [33:0] h2_reg;
    logic signed [15:0] d2_reg [3], n2_reg [3];
    logic        [15:0] eta2_reg;
    logic               refl2_reg;

    logic signed [25:0] h20_3_reg;
    logic signed [51:0] rf3_reg [3];
    logic signed [15:0] d3_reg [3], n3_reg [3];
    logic        [15:0] eta3_reg;
    logic        [31:0] esq3_reg;
    logic               refl3_reg;

    logic signed [51:0] hsq4_reg;
    logic signed [42:0] a4_reg [3];
    logic signed [15:0] ro4_reg [3], n4_reg [3];
    logic        [15:0] eta4_reg;
    logic        [31:0] esq4_reg;
    logic               refl4_reg;

    logic signed [29:0] t5_reg;
    logic signed [60:0] e5_reg [3];
    logic signed [15:0] ro5_reg [3], n5_reg [3];
    logic        [31:0] esq5_reg;
    logic               refl5_reg;

    logic signed [63:0] pr6_reg;
    logic signed [60:0] e6_reg [3];
    logic signed [15:0] ro6_reg [3], n6_reg [3];
    logic               refl6_reg;

    logic        [63:0] rad7_reg;
    mid_t               b7_reg;

    always_ff @(posedge clk)
    begin
        logic signed [63:0] tmp;
        logic signed [63:0] disc;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i] <= 32'(d0[i]) * 32'(n0[i]);
                d1_reg[i] <= d0[i];
                n1_reg[i] <= n0[i];
                d2_reg[i] <= d1_reg[i];
                n2_reg[i] <= n1_reg[i];
                rf3_reg[i] <= (52'(d2_reg[i]) <<< 28)
                            - ((52'(h2_reg) * 52'(n2_reg[i])) <<< 1);
                d3_reg[i] <= d2_reg[i];
                n3_reg[i] <= n2_reg[i];
                a4_reg[i] <= (43'(d3_reg[i]) <<< 20) - 43'(h20_3_reg) * 43'(n3_reg[i]);
                ro4_reg[i] <= sat16(64'((rf3_reg[i] + (52'sd1 <<< 27)) >>> 28));
                n4_reg[i] <= n3_reg[i];
                e5_reg[i] <= 61'($signed({1'b0, eta4_reg})) * 61'(a4_reg[i]);
                ro5_reg[i] <= ro4_reg[i];
                n5_reg[i] <= n4_reg[i];
                e6_reg[i] <= e5_reg[i];
                ro6_reg[i] <= ro5_reg[i];
                n6_reg[i] <= n5_reg[i];
            end
            eta1_reg  <= ray.ratio;
            refl1_reg <= refl_in;
            h2_reg    <= 34'(p1_reg[0]) + 34'(p1_reg[1]) + 34'(p1_reg[2]);
            eta2_reg  <= eta1_reg;
            refl2_reg <= refl1_reg;
            h20_3_reg <= 26'((h2_reg + 34'sd128) >>> 8);
            eta3_reg  <= eta2_reg;
            esq3_reg  <= 32'(eta2_reg) * 32'(eta2_reg);
            refl3_reg <= refl2_reg;
            hsq4_reg  <= 52'(h20_3_reg) * 52'(h20_3_reg);
            eta4_reg  <= eta3_reg;
            esq4_reg  <= esq3_reg;
            refl4_reg <= refl3_reg;
            tmp = (64'sd1 <<< 40) - 64'(hsq4_reg) + (64'sd1 <<< 19);
            t5_reg    <= 30'(tmp >>> 20);
            esq5_reg  <= esq4_reg;
            refl5_reg <= refl4_reg;
            pr6_reg   <= 64'($signed({1'b0, esq5_reg})) * 64'(t5_reg);
            refl6_reg <= refl5_reg;
            disc = (64'sd1 <<< 44) - pr6_reg;
            rad7_reg  <= (disc > 0) ? 64'(disc) : 64'd0;
            for (int i = 0; i < 3; i++)
            begin
                b7_reg.e[i]     <= e6_reg[i];
                b7_reg.n[i]     <= n6_reg[i];
                b7_reg.tl.ro[i] <= ro6_reg[i];
            end
            b7_reg.tl.refl <= refl6_reg;
            b7_reg.tl.dpos <= (disc > 0);
        end
    end

    // First square root, side data delayed alongside
    logic [31:0] s_root;
    mid_t        dl1_reg [SQRT_LAT];

    rrf_sqrt u_sqrt_disc (
        .clk  (clk),
        .en   (en),
        .rad  (rad7_reg),
        .root (s_root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl1_reg[0] <= b7_reg;
            for (int k = 1; k < SQRT_LAT; k++)
                dl1_reg[k] <= dl1_reg[k-1];
        end
    end

    // Stage 40 to 47: refracted vector, normalizing shift, squared length
    mid_t               b39;
    logic signed [47:0] sn40_reg [3];
    mid_t               b40_reg;
    logic signed [61:0] r41_reg [3];
    tail_t              t41_reg;
    logic signed [61:0] r42_reg [3];
    logic        [63:0] orv42_reg;
    tail_t              t42_reg;
    logic signed [61:0] r43_reg [3];
    logic [7:0]         nz43_reg;
    logic [2:0]         pos43_reg [8];
    tail_t              t43_reg;
    logic signed [61:0] r44_reg [3];
    logic [6:0]         bl44_reg;
    tail_t              t44_reg;
    logic signed [31:0] rn45_reg [3];
    logic               mz45_reg;
    tail_t              t45_reg;
    logic        [61:0] sq46_reg [3];
    logic signed [31:0] rn46_reg [3];
    logic               mz46_reg;
    tail_t              t46_reg;
    logic        [63:0] ssum47_reg;
    back_t              b47_reg;

    assign b39 = dl1_reg[SQRT_LAT-1];

    always_ff @(posedge clk)
    begin
        logic [63:0] orv;
        logic [6:0]  bl;
        logic [6:0]  k;
        logic [2:0]  pos;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                sn40_reg[i] <= 48'($signed({1'b0, s_root[30:0]})) * 48'($signed(b39.n[i]));
            b40_reg <= b39;
            for (int i = 0; i < 3; i++)
                r41_reg[i] <= 62'($signed(b40_reg.e[i])) - (62'(sn40_reg[i]) <<< 10);
            t41_reg <= b40_reg.tl;
            orv = '0;
            for (int i = 0; i < 3; i++)
            begin
                orv = orv | mag64(64'(r41_reg[i]));
                r42_reg[i] <= r41_reg[i];
            end
            orv42_reg <= orv;
            t42_reg <= t41_reg;
            // leading one within each byte
            for (int j = 0; j < 8; j++)
            begin
                nz43_reg[j] <= |orv42_reg[8*j +: 8];
                pos = 3'd0;
                for (int b = 0; b < 8; b++)
                    if (orv42_reg[8*j + b])
                        pos = 3'(b);
                pos43_reg[j] <= pos;
            end
            for (int i = 0; i < 3; i++)
                r43_reg[i] <= r42_reg[i];
            t43_reg <= t42_reg;
            // bit length of the largest magnitude
            bl = 7'd0;
            for (int j = 0; j < 8; j++)
                if (nz43_reg[j])
                    bl = 7'(8 * j) + 7'(pos43_reg[j]) + 7'd1;
            bl44_reg <= bl;
            for (int i = 0; i < 3; i++)
                r44_reg[i] <= r43_reg[i];
            t44_reg <= t43_reg;
            // scale so the largest magnitude lies in [2^29, 2^30]
            for (int i = 0; i < 3; i++)
            begin
                if (bl44_reg > 7'd30)
                begin
                    k = bl44_reg - 7'd30;
                    rn45_reg[i] <= 32'((64'(r44_reg[i]) + (64'sd1 <<< (k - 7'd1))) >>> k);
                end
                else
                    rn45_reg[i] <= 32'(64'(r44_reg[i]) <<< (7'd30 - bl44_reg));
            end
            mz45_reg <= (bl44_reg == 7'd0);
            t45_reg <= t44_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq46_reg[i] <= 62'(64'(rn45_reg[i]) * 64'(rn45_reg[i]));
                rn46_reg[i] <= rn45_reg[i];
            end
            mz46_reg <= mz45_reg;
            t46_reg <= t45_reg;
            ssum47_reg <= 64'(sq46_reg[0]) + 64'(sq46_reg[1]) + 64'(sq46_reg[2]);
            for (int i = 0; i < 3; i++)
                b47_reg.rn[i] <= rn46_reg[i];
            b47_reg.tl <= t46_reg;
            b47_reg.mz <= mz46_reg;
        end
    end

    // Second square root gives the vector length
    logic [31:0] len_root;
    back_t       dl2_reg [SQRT_LAT];

    rrf_sqrt u_sqrt_len (
        .clk  (clk),
        .en   (en),
        .rad  (ssum47_reg),
        .root (len_root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl2_reg[0] <= b47_reg;
            for (int k = 1; k < SQRT_LAT; k++)
                dl2_reg[k] <= dl2_reg[k-1];
        end
    end

    // Stage 80: divide setup, rounding half away from zero
    back_t       b79;
    logic [47:0] num80_reg [3];
    logic [31:0] den80_reg;
    fin_t        f80_reg;

    assign b79 = dl2_reg[SQRT_LAT-1];

    always_ff @(posedge clk)
    begin
        logic [63:0] m;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m = mag64(64'($signed(b79.rn[i])));
                num80_reg[i] <= (48'(m) << 14) + 48'(len_root >> 1);
                f80_reg.neg[i] <= b79.rn[i][31];
            end
            den80_reg <= len_root;
            f80_reg.tl <= b79.tl;
            f80_reg.zero <= b79.mz || (len_root == 32'd0);
        end
    end

    logic [31:0] q [3];
    fin_t        dl3_reg [DIV_LAT];

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        rrf_div u_div (
            .clk (clk),
            .en  (en),
            .num (num80_reg[g]),
            .den (den80_reg),
            .quo (q[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl3_reg[0] <= f80_reg;
            for (int k = 1; k < DIV_LAT; k++)
                dl3_reg[k] <= dl3_reg[k-1];
        end
    end

    // Final stage: pick mirror, refracted, or zero vector
    fin_t               f112;
    logic signed [15:0] o [3];
    logic               ok;
    vec_res_t           res_reg;

    assign f112 = dl3_reg[DIV_LAT-1];

    always_comb
    begin
        logic signed [63:0] qs;
        ok = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            qs = $signed({32'h0, q[i]});
            if (f112.tl.refl)
                o[i] = $signed(f112.tl.ro[i]);
            else if (!f112.tl.dpos || f112.zero)
                o[i] = 16'sd0;
            else
                o[i] = sat16(f112.neg[i] ? -qs : qs);
        end
        if (!f112.tl.refl && !f112.tl.dpos)
            ok = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.out_x  <= o[0];
            res_reg.out_y  <= o[1];
            res_reg.out_z  <= o[2];
            res_reg.ray_ok <= ok;
        end
    end

    assign res = res_reg;

endmodule

/* rtl/core/rrf_fres.sv */
// Fresnel path: Schlick reflectance from the index ratio and incidence cosine.
`timescale 1ns / 1ps

module rrf_fres
    import rrf_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic        [15:0] ratio,
    input  logic signed [15:0] cos_angle,
    output logic        [15:0] reflectance
);

    // Stage 1: r0 division setup; the sign of r0 drops out when squared
    logic        [47:0] num1_reg;
    logic        [31:0] den1_reg;
    logic signed [16:0] x1_reg;

    always_ff @(posedge clk)
    begin
        logic [15:0] m;
        logic [31:0] den;
        if (en)
        begin
            m   = (ratio > 16'd4096) ? ratio - 16'd4096 : 16'd4096 - ratio;
            den = 32'(ratio) + 32'd4096;
            num1_reg <= (48'(m) << 30) + 48'(den >> 1);
            den1_reg <= den;
            x1_reg   <= 17'(18'sd16384 - 18'(cos_angle));
        end
    end

    logic [31:0]        q;
    logic signed [16:0] xd_reg [DIV_LAT];

    rrf_div u_div_r0 (
        .clk (clk),
        .en  (en),
        .num (num1_reg),
        .den (den1_reg),
        .quo (q)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xd_reg[0] <= x1_reg;
            for (int k = 1; k < DIV_LAT; k++)
                xd_reg[k] <= xd_reg[k-1];
        end
    end

    // Stages 2 to 7: r0 squared, fifth power, blend
    logic signed [16:0] xq;
    logic        [63:0] q2_2_reg;
    logic signed [41:0] p2_reg, p3_reg, p4_reg;
    logic signed [16:0] x2_reg, x3_reg, x4_reg;
    logic        [30:0] r0sq3_reg, r0sq4_reg, r0sq5_reg, r0sq6_reg;
    logic signed [31:0] pc5_reg;
    logic signed [63:0] prod6_reg;
    logic        [15:0] refl7_reg;

    assign xq = xd_reg[DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        logic signed [63:0] tmp;
        logic signed [63:0] rr;
        if (en)
        begin
            q2_2_reg  <= 64'(q) * 64'(q);
            p2_reg    <= (42'(xq) * 42'(xq)) <<< 2;
            x2_reg    <= xq;
            r0sq3_reg <= 31'((q2_2_reg + (64'd1 << 29)) >> 30);
            p3_reg    <= 42'((60'(p2_reg) * 60'(x2_reg) + (60'sd1 <<< 13)) >>> 14);
            x3_reg    <= x2_reg;
            r0sq4_reg <= r0sq3_reg;
            p4_reg    <= 42'((60'(p3_reg) * 60'(x3_reg) + (60'sd1 <<< 13)) >>> 14);
            x4_reg    <= x3_reg;
            r0sq5_reg <= r0sq4_reg;
            tmp = (64'(p4_reg) * 64'(x4_reg) + (64'sd1 <<< 13)) >>> 14;
            pc5_reg   <= (tmp > (64'sd1 <<< 30)) ? (32'sd1 <<< 30) : 32'(tmp);
            r0sq6_reg <= r0sq5_reg;
            prod6_reg <= 64'($signed({1'b0, 31'(31'h4000_0000 - r0sq5_reg)})) * 64'(pc5_reg);
            rr = 64'($signed({1'b0, r0sq6_reg}))
               + ((prod6_reg + (64'sd1 <<< 29)) >>> 30);
            rr = (rr + 64'sd16384) >>> 15;
            if (rr < 0)
                refl7_reg <= 16'd0;
            else if (rr > 64'sd32768)
                refl7_reg <= 16'h8000;
            else
                refl7_reg <= rr[15:0];
        end
    end

    assign reflectance = refl7_reg;

endmodule

/* rtl/core/ray_reflect_refract_fresnel.sv */
// Top level: stream ports, pipeline control and result assembly.
`timescale 1ns / 1ps

// Fixed-point ray shading pipeline. Mode 0 mirrors the direction about the
// normal, mode 1 refracts by Snell's law and normalizes (ray_ok clear on total
// internal reflection), mode 2 gives the Schlick reflectance; mode 3 returns
// zeros. One transaction is accepted per clock while s_tready is high; the
// pipeline depth is set by the refraction path, which runs two 32-stage
// square roots and a 32-stage divider in series. The whole pipeline advances
// together; while the output is held it still moves on as long as the last
// stage is empty, and input stops once a valid transaction sits in the last
// stage, even if bubbles remain further up.
module ray_reflect_refract_fresnel
    import rrf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, ratio, cos_angle
    input  logic [127:0] s_tdata,
    // mode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z, reflectance
    output logic [63:0]  m_tdata,
    // ray_ok
    output logic         m_tuser
);

    // Pipeline advance: output free, or tail slot empty
    logic load_out;
    logic en;
    logic vl_reg [VEC_LAT];
    mode_t md_reg [VEC_LAT];
    logic out_v_reg;

    assign load_out = !out_v_reg || m_tready;
    assign en       = load_out || !vl_reg[VEC_LAT-1];
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < VEC_LAT; k++)
                vl_reg[k] <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vl_reg[0] <= s_tvalid;
                for (int k = 1; k < VEC_LAT; k++)
                    vl_reg[k] <= vl_reg[k-1];
            end
            if (load_out)
                out_v_reg <= vl_reg[VEC_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            md_reg[0] <= mode_t'(s_tuser);
            for (int k = 1; k < VEC_LAT; k++)
                md_reg[k] <= md_reg[k-1];
        end
    end

    // Vector path
    ray_t     ray;
    vec_res_t vres;

    always_comb
    begin
        ray.dir_x  = s_tdata[15:0];
        ray.dir_y  = s_tdata[31:16];
        ray.dir_z  = s_tdata[47:32];
        ray.norm_x = s_tdata[63:48];
        ray.norm_y = s_tdata[79:64];
        ray.norm_z = s_tdata[95:80];
        ray.ratio  = s_tdata[111:96];
    end

    rrf_vec u_vec (
        .clk     (clk),
        .en      (en),
        .refl_in (s_tuser == MODE_REFLECT),
        .ray     (ray),
        .res     (vres)
    );

    // Fresnel path, delayed to line up with the vector path
    logic [15:0] pr_reg [SCH_PAD];
    logic [15:0] pc_reg [SCH_PAD];
    logic [15:0] refl;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg[0] <= s_tdata[111:96];
            pc_reg[0] <= s_tdata[127:112];
            for (int k = 1; k < SCH_PAD; k++)
            begin
                pr_reg[k] <= pr_reg[k-1];
                pc_reg[k] <= pc_reg[k-1];
            end
        end
    end

    rrf_fres u_fres (
        .clk         (clk),
        .en          (en),
        .ratio       (pr_reg[SCH_PAD-1]),
        .cos_angle   ($signed(pc_reg[SCH_PAD-1])),
        .reflectance (refl)
    );

    // Result assembly by mode
    logic [63:0] out_data_reg;
    logic        out_ok_reg;

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            case (md_reg[VEC_LAT-1])
                MODE_REFLECT, MODE_REFRACT:
                begin
                    out_data_reg <= {16'h0000, vres.out_z, vres.out_y, vres.out_x};
                    out_ok_reg   <= vres.ray_ok;
                end
                MODE_SCHLICK:
                begin
                    out_data_reg <= {refl, 48'h0};
                    out_ok_reg   <= 1'b0;
                end
                default:
                begin
                    out_data_reg <= '0;
                    out_ok_reg   <= 1'b0;
                end
            endcase
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

    // Reflectance never exceeds 1.0
    a_refl_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[63:48] <= 16'h8000))
        else $error("reflectance above 1.0");

    // A successful ray carries no reflectance
    a_ok_no_refl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[63:48] == 16'h0000))
        else $error("ray_ok with nonzero reflectance");

    // Input stalls only when the output is held and the tail slot is full
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (out_v_reg && !m_tready && vl_reg[VEC_LAT-1]))
        else $error("input stalled without cause");

    // A held result is not replaced
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(out_data_reg) && $stable(out_ok_reg))
        else $error("held result changed");

endmodule
